// ===== hw/rtl/kah_pkg.sv =====
`timescale 1ns / 1ps

package kah_pkg;

  localparam int KEY_ROWS_DEF = 4;
  localparam int KEY_COLS_DEF = 16;

  localparam int COUNT_W  = 8;
  localparam int TOTAL_W  = 16;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // q = floor(768 * count / total): dividend, quotient and divisor widths
  localparam int N_W = 18;
  localparam int Q_W = 10;
  localparam int T_W = TOTAL_W;
  localparam int DIV_CNT_W = $clog2(Q_W);

  localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'd255;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX       = 16'hFFFF;
  localparam logic [COUNT_W-1:0] PEAK_LIMIT_RST  = 8'd191;
  localparam logic [TOTAL_W-1:0] TOTAL_LIMIT_RST = 16'd16000;

  // register select is paddr[2]
  localparam logic REG_PEAK_LIMIT  = 1'b0;
  localparam logic REG_TOTAL_LIMIT = 1'b1;

  // gradient endpoints in units of 1/510
  localparam logic [17:0] GRAD_LO     = 18'd51;
  localparam logic [17:0] GRAD_HI     = 18'd510;
  localparam logic [17:0] GRAD_STEP   = 18'd459;
  localparam logic [17:0] GRAD_LO_256 = 18'd13056;
  localparam logic [17:0] GRAD_HI_256 = 18'd130560;
  localparam logic [7:0]  CH_FULL     = 8'd255;
  localparam logic [7:0]  CH_TINT     = 8'd25;

  typedef enum logic [1:0] {
    ACT_KEY    = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_RENDER = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    SEG_BLACK_GREEN  = 2'd0,
    SEG_GREEN_YELLOW = 2'd1,
    SEG_YELLOW_RED   = 2'd2
  } seg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVT_UPD,
    ST_TICK,
    ST_REN_RD,
    ST_REN_CHK,
    ST_REN_DIV,
    ST_REN_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] key_row;
    logic [3:0] key_col;
    logic       injected;
    logic       toggled_on;
  } evt_t;

  typedef struct packed {
    logic [1:0] out_row;
    logic [3:0] out_col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } heat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic           start;
    logic [N_W-1:0] dividend;
    logic [T_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Blend along black, green, yellow, red; each channel is
  // floor((c1*256 + (c2-c1)*f) / 512) with constant endpoints.
  function automatic rgb_t heat_rgb(input logic is_red, input logic [Q_W-1:0] q);
    rgb_t        c;
    logic [7:0]  f;
    logic [17:0] p51;
    logic [17:0] p459;
    logic [17:0] p510;
    logic [17:0] rise;
    logic [17:0] fall;
    f    = q[7:0];
    p51  = 18'(f) * GRAD_LO;
    p459 = 18'(f) * GRAD_STEP;
    p510 = 18'(f) * GRAD_HI;
    rise = GRAD_LO_256 + p459;
    fall = GRAD_HI_256 - p459;
    case (seg_e'(q[9:8]))
      SEG_BLACK_GREEN: begin
        c.red   = p51[16:9];
        c.green = p510[16:9];
        c.blue  = p51[16:9];
      end
      SEG_GREEN_YELLOW: begin
        c.red   = rise[16:9];
        c.green = CH_FULL;
        c.blue  = CH_TINT;
      end
      default: begin
        c.red   = CH_FULL;
        c.green = fall[16:9];
        c.blue  = CH_TINT;
      end
    endcase
    if (is_red) begin
      c.red   = CH_FULL;
      c.green = CH_TINT;
      c.blue  = CH_TINT;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/kah_stream_if.sv =====
`timescale 1ns / 1ps

interface kah_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/key_activity_heatmap.sv =====
// Key activity heatmap: press counts per key of a KEY_ROWS x KEY_COLS matrix.
// evt_i is a valid/ready channel of commands: key event, housekeeping tick or
// render. heat_o carries one colour per key of a render, in row-major order,
// with last set on the final key. An APB port holds peak_limit (address 0)
// and total_limit (address 4); pready is always high.
// Sequencing: evt_i takes one command at a time and is ready only while the
// sequencer idles. A key event reads the count, then writes the update to the
// count store. A tick that halves reads one count and writes one back per
// cycle across all KEY_ROWS*KEY_COLS slots; a tick under the limits is taken
// without leaving idle. A render steps each key through a read, a check, the
// shared 10-step restoring divider that forms 768*count/total, and emit; a key
// whose count reaches the total skips the divider.
// Reset clears all counts, the total and the peak at once, and loads the
// limits with 191 and 16000. When the receiver stalls, the colour is held in
// the output register and the render waits; nothing is dropped.
`timescale 1ns / 1ps

module key_activity_heatmap #(
  parameter int KEY_ROWS = kah_pkg::KEY_ROWS_DEF,
  parameter int KEY_COLS = kah_pkg::KEY_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  kah_stream_if.sink                    evt_i,
  kah_stream_if.source                  heat_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kah_pkg::ADDR_W-1:0]    paddr,
  input  logic [kah_pkg::DATA_W-1:0]    pwdata,
  output logic [kah_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int SLOTS = KEY_ROWS * KEY_COLS;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW    = $clog2(SLOTS + 1);
  localparam int CNW   = kah_pkg::COUNT_W;
  localparam int TOW   = kah_pkg::TOTAL_W;

  kah_pkg::state_e state_q, state_d;

  logic [SW-1:0]  slot_q, slot_d;
  logic [SW-1:0]  slot_m1;
  logic [1:0]     row_q, row_d;
  logic [3:0]     col_q, col_d;
  logic [TOW-1:0] total_q, total_d;
  logic [CNW-1:0] peak_q, peak_d;
  logic           red_q, red_d;
  kah_pkg::heat_t out_q, out_d;
  logic           out_vld_q, out_vld_d;

  logic [CNW-1:0] peak_limit;
  logic [TOW-1:0] total_limit;

  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [CNW-1:0] rd_data;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [CNW-1:0] wr_data;

  kah_pkg::div_req_t  div_req;
  kah_pkg::div_stat_t div_stat;
  logic [kah_pkg::Q_W-1:0] quot;

  kah_pkg::evt_t  evt;
  logic           evt_rdy;
  logic           evt_ok;
  logic [AW-1:0]  evt_idx;
  logic           over;
  logic [TOW-1:0] denom;
  logic           is_red;
  logic           out_free;
  logic           ren_last;
  logic [CNW-1:0] inc;
  logic [CNW-1:0] half;
  kah_pkg::rgb_t  rgb;

  kah_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .peak_limit_o  (peak_limit),
    .total_limit_o (total_limit)
  );

  kah_count_mem #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  kah_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  assign evt      = evt_i.payload;
  assign evt_ok   = !evt.injected && evt.toggled_on &&
                    (int'(evt.key_row) < KEY_ROWS) && (int'(evt.key_col) < KEY_COLS);
  assign evt_idx  = AW'(int'(evt.key_row) * KEY_COLS + int'(evt.key_col));
  assign over     = (peak_q > peak_limit) || (total_q > total_limit);
  assign denom    = (total_q == '0) ? TOW'(1) : total_q;
  assign is_red   = TOW'(rd_data) >= denom;
  assign out_free = !out_vld_q || heat_o.ready;
  assign ren_last = (row_q == 2'(KEY_ROWS - 1)) && (col_q == 4'(KEY_COLS - 1));
  assign slot_m1  = slot_q - SW'(1);
  assign inc      = (rd_data == kah_pkg::COUNT_MAX) ? rd_data : rd_data + CNW'(1);
  assign half     = rd_data >> 1;
  assign rgb      = kah_pkg::heat_rgb(red_q, quot);

  always_comb begin
    state_d = state_q;
    case (state_q)
      kah_pkg::ST_IDLE: begin
        if (evt_i.valid) begin
          case (kah_pkg::action_e'(evt.action))
            kah_pkg::ACT_KEY:    if (evt_ok) state_d = kah_pkg::ST_EVT_UPD;
            kah_pkg::ACT_TICK:   if (over) state_d = kah_pkg::ST_TICK;
            kah_pkg::ACT_RENDER: state_d = kah_pkg::ST_REN_RD;
            default:             state_d = kah_pkg::ST_IDLE;
          endcase
        end
      end
      kah_pkg::ST_EVT_UPD: state_d = kah_pkg::ST_IDLE;
      kah_pkg::ST_TICK: begin
        if (slot_q == SW'(SLOTS)) state_d = kah_pkg::ST_IDLE;
      end
      kah_pkg::ST_REN_RD:  state_d = kah_pkg::ST_REN_CHK;
      kah_pkg::ST_REN_CHK: state_d = is_red ? kah_pkg::ST_REN_EMIT : kah_pkg::ST_REN_DIV;
      kah_pkg::ST_REN_DIV: begin
        if (div_stat.done) state_d = kah_pkg::ST_REN_EMIT;
      end
      kah_pkg::ST_REN_EMIT: begin
        if (out_free) state_d = ren_last ? kah_pkg::ST_IDLE : kah_pkg::ST_REN_RD;
      end
      default: state_d = kah_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    slot_d           = slot_q;
    row_d            = row_q;
    col_d            = col_q;
    total_d          = total_q;
    peak_d           = peak_q;
    red_d            = red_q;
    out_d            = out_q;
    out_vld_d        = out_vld_q && !heat_o.ready;
    evt_rdy          = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = slot_q[AW-1:0];
    wr_en            = 1'b0;
    wr_addr          = slot_q[AW-1:0];
    wr_data          = inc;
    div_req.start    = 1'b0;
    div_req.dividend = (kah_pkg::N_W'(rd_data) << 9) + (kah_pkg::N_W'(rd_data) << 8);
    div_req.divisor  = denom;
    case (state_q)
      kah_pkg::ST_IDLE: begin
        evt_rdy = 1'b1;
        if (evt_i.valid) begin
          case (kah_pkg::action_e'(evt.action))
            kah_pkg::ACT_KEY: begin
              if (evt_ok) begin
                rd_en   = 1'b1;
                rd_addr = evt_idx;
                slot_d  = SW'(evt_idx);
              end
            end
            kah_pkg::ACT_TICK: begin
              // rebuild total and peak from the halved counts
              if (over) begin
                slot_d  = '0;
                total_d = '0;
                peak_d  = '0;
              end
            end
            kah_pkg::ACT_RENDER: begin
              slot_d = '0;
              row_d  = '0;
              col_d  = '0;
            end
            default: ;
          endcase
        end
      end
      kah_pkg::ST_EVT_UPD: begin
        wr_en   = 1'b1;
        wr_data = inc;
        total_d = (total_q == kah_pkg::TOTAL_MAX) ? total_q : total_q + TOW'(1);
        if (inc > peak_q) peak_d = inc;
      end
      kah_pkg::ST_TICK: begin
        // read slot n while writing back slot n-1
        if (slot_q != SW'(SLOTS)) begin
          rd_en  = 1'b1;
          slot_d = slot_q + SW'(1);
        end
        if (slot_q != '0) begin
          wr_en   = 1'b1;
          wr_addr = slot_m1[AW-1:0];
          wr_data = half;
          total_d = total_q + TOW'(half);
          if (half > peak_q) peak_d = half;
        end
      end
      kah_pkg::ST_REN_RD: begin
        rd_en = 1'b1;
      end
      kah_pkg::ST_REN_CHK: begin
        red_d         = is_red;
        div_req.start = !is_red;
      end
      kah_pkg::ST_REN_DIV: ;
      kah_pkg::ST_REN_EMIT: begin
        if (out_free) begin
          out_vld_d     = 1'b1;
          out_d.out_row = row_q;
          out_d.out_col = col_q;
          out_d.red     = rgb.red;
          out_d.green   = rgb.green;
          out_d.blue    = rgb.blue;
          out_d.last    = ren_last;
          if (!ren_last) begin
            slot_d = slot_q + SW'(1);
            if (col_q == 4'(KEY_COLS - 1)) begin
              col_d = '0;
              row_d = row_q + 2'd1;
            end else begin
              col_d = col_q + 4'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kah_pkg::ST_IDLE;
      slot_q    <= '0;
      row_q     <= '0;
      col_q     <= '0;
      total_q   <= '0;
      peak_q    <= '0;
      red_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      row_q     <= row_d;
      col_q     <= col_d;
      total_q   <= total_d;
      peak_q    <= peak_d;
      red_q     <= red_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign evt_i.ready    = evt_rdy;
  assign heat_o.valid   = out_vld_q;
  assign heat_o.payload = out_q;

  a_total_covers_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    TOW'(peak_q) <= total_q)
    else $error("peak count exceeds total presses");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.ready |-> state_q == kah_pkg::ST_IDLE)
    else $error("command taken while sequencer busy");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == kah_pkg::ST_REN_DIV)
    else $error("divider finished outside render divide step");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(heat_o.valid) |-> $past(state_q == kah_pkg::ST_REN_EMIT))
    else $error("colour loaded outside emit step");

endmodule

// ===== hw/rtl/kah_apb_regs.sv =====
`timescale 1ns / 1ps

module kah_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kah_pkg::ADDR_W-1:0]    paddr,
  input  logic [kah_pkg::DATA_W-1:0]    pwdata,
  output logic [kah_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output logic [kah_pkg::COUNT_W-1:0]   peak_limit_o,
  output logic [kah_pkg::TOTAL_W-1:0]   total_limit_o
);

  logic                        wr_en;
  logic [kah_pkg::COUNT_W-1:0] peak_limit_q;
  logic [kah_pkg::TOTAL_W-1:0] total_limit_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_limit_q  <= kah_pkg::PEAK_LIMIT_RST;
      total_limit_q <= kah_pkg::TOTAL_LIMIT_RST;
    end else if (wr_en) begin
      if (paddr[2] == kah_pkg::REG_PEAK_LIMIT) begin
        peak_limit_q <= pwdata[kah_pkg::COUNT_W-1:0];
      end else begin
        total_limit_q <= pwdata[kah_pkg::TOTAL_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == kah_pkg::REG_TOTAL_LIMIT) begin
      prdata = kah_pkg::DATA_W'(total_limit_q);
    end else begin
      prdata = kah_pkg::DATA_W'(peak_limit_q);
    end
  end

  assign peak_limit_o  = peak_limit_q;
  assign total_limit_o = total_limit_q;

endmodule

// ===== hw/rtl/kah_count_mem.sv =====
`timescale 1ns / 1ps

module kah_count_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [kah_pkg::COUNT_W-1:0] rd_data_o,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [kah_pkg::COUNT_W-1:0] wr_data_i
);

  logic [kah_pkg::COUNT_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]            vld_q;
  logic [kah_pkg::COUNT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= vld_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/kah_div.sv =====
`timescale 1ns / 1ps

module kah_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kah_pkg::div_req_t        req_i,
  output kah_pkg::div_stat_t       stat_o,
  output logic [kah_pkg::Q_W-1:0]  quot_o
);

  localparam int QW = kah_pkg::Q_W;
  localparam int TW = kah_pkg::T_W;
  localparam int NW = kah_pkg::N_W;
  localparam int CW = kah_pkg::DIV_CNT_W;

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [TW-1:0] rem_q;
  logic [TW-1:0] dvs_q;
  logic [QW-1:0] num_q;

  logic [TW:0]   trial;
  logic [TW:0]   diff;
  logic          ge;
  logic          last_step;

  // one restoring step a cycle; the quotient shifts in where the dividend leaves
  assign trial     = {rem_q, num_q[QW-1]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign diff      = trial - {1'b0, dvs_q};
  assign last_step = cnt_q == CW'(QW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= TW'(req_i.dividend[NW-1:QW]);
      num_q <= req_i.dividend[QW-1:0];
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[TW-1:0] : trial[TW-1:0];
      num_q <= {num_q[QW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = num_q;

endmodule
